/* hdl/lwis_pkg.sv */
package lwis_pkg;

	localparam int ID_W     = 16;
	localparam int WEIGHT_W = 32;
	localparam int OP_W     = 2;

	localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD      = 2'd1;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// saturated weight, never qualifies as least loaded
	localparam logic [WEIGHT_W-1:0] WEIGHT_LIMIT = 32'hffff_ffff;

	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [WEIGHT_W-1:0] weight;
	} entry_t;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [ID_W-1:0]     server_id;
		logic [WEIGHT_W-1:0] weight_delta;
	} cmd_t;

	typedef struct packed {
		logic [ID_W-1:0] least_id;
		logic            status;
	} res_t;

endpackage

/* hdl/lwis_if.sv */
interface lwis_in_if;
	logic                            valid;
	logic                            ready;
	logic [lwis_pkg::OP_W-1:0]       operation;
	logic [lwis_pkg::ID_W-1:0]       server_id;
	logic [lwis_pkg::WEIGHT_W-1:0]   weight_delta;

	modport source (output valid, output operation, output server_id, output weight_delta,
		input ready);
	modport sink (input valid, input operation, input server_id, input weight_delta,
		output ready);
endinterface

interface lwis_out_if;
	logic                      valid;
	logic                      ready;
	logic [lwis_pkg::ID_W-1:0] least_id;
	logic                      status;

	modport source (output valid, output least_id, output status, input ready);
	modport sink (input valid, input least_id, input status, output ready);
endinterface

/* hdl/lwis_table.sv */
module lwis_table #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output lwis_pkg::entry_t      rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  lwis_pkg::entry_t      wr_data
);

	lwis_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hdl/lwis_engine.sv */
module lwis_engine #(
	parameter int MAX_ENTRIES = 16,
	parameter int AW          = 4,
	parameter int CW          = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  lwis_pkg::cmd_t        cmd,
	output logic                  res_valid,
	input  logic                  res_ready,
	output lwis_pkg::res_t        res,
	output logic                  rd_en,
	output logic [AW-1:0]         rd_addr,
	input  lwis_pkg::entry_t      rd_data,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output lwis_pkg::entry_t      wr_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                      state_q;
	logic [CW-1:0]                   cnt_q;
	logic [CW-1:0]                   rd_idx_q;
	logic                            pend_s1;
	logic [AW-1:0]                   idx_s1;
	logic [lwis_pkg::OP_W-1:0]       op_q;
	logic [lwis_pkg::ID_W-1:0]       id_q;
	logic [lwis_pkg::WEIGHT_W-1:0]   delta_q;
	logic                            found_q;
	logic [lwis_pkg::WEIGHT_W-1:0]   best_w_q;
	logic [lwis_pkg::ID_W-1:0]       best_id_q;
	logic                            status_q;

	logic                            hit;
	logic [lwis_pkg::WEIGHT_W-1:0]   w_eff;
	logic                            scan_end;
	logic                            need_app;
	logic                            room;
	logic                            app_ok;
	logic [lwis_pkg::WEIGHT_W-1:0]   app_w;
	logic                            cand_ok;
	logic [lwis_pkg::WEIGHT_W-1:0]   cand_w;
	logic [lwis_pkg::ID_W-1:0]       cand_id;
	logic                            take;

	always_comb begin
		cmd_ready = (state_q == ST_IDLE);
		rd_en     = (state_q == ST_SCAN) && (rd_idx_q != cnt_q);
		rd_addr   = rd_idx_q[AW-1:0];

		// first matching entry only; later duplicates keep their weight
		hit   = pend_s1 && (op_q == lwis_pkg::OP_ADD) && !found_q && (rd_data.id == id_q);
		w_eff = hit ? rd_data.weight + delta_q : rd_data.weight;

		scan_end = (state_q == ST_SCAN) && !pend_s1 && (rd_idx_q == cnt_q);
		need_app = (op_q == lwis_pkg::OP_REGISTER) || ((op_q == lwis_pkg::OP_ADD) && !found_q);
		room     = (cnt_q != CW'(MAX_ENTRIES));
		app_ok   = scan_end && need_app && room;
		app_w    = (op_q == lwis_pkg::OP_REGISTER) ? '0 : delta_q;

		wr_en          = hit || app_ok;
		wr_addr        = hit ? idx_s1 : cnt_q[AW-1:0];
		wr_data.id     = id_q;
		wr_data.weight = hit ? w_eff : app_w;

		// the appended entry is last in order, so it is compared after the scan
		cand_ok = pend_s1 || app_ok;
		cand_w  = pend_s1 ? w_eff : app_w;
		cand_id = pend_s1 ? rd_data.id : id_q;
		take    = cand_ok && (cand_w < best_w_q);

		res_valid    = (state_q == ST_DONE);
		res.least_id = best_id_q;
		res.status   = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			if (app_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		if (state_q == ST_IDLE && cmd_valid) begin
			op_q      <= cmd.operation;
			id_q      <= cmd.server_id;
			delta_q   <= cmd.weight_delta;
			rd_idx_q  <= '0;
			found_q   <= 1'b0;
			best_w_q  <= lwis_pkg::WEIGHT_LIMIT;
			best_id_q <= '0;
			status_q  <= lwis_pkg::STATUS_DONE;
		end else begin
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (hit) begin
				found_q <= 1'b1;
			end
			if (take) begin
				best_w_q  <= cand_w;
				best_id_q <= cand_id;
			end
			if (scan_end && need_app && !room) begin
				status_q <= lwis_pkg::STATUS_FULL;
			end
		end
	end

endmodule

/* hdl/least_weight_id_selector.sv */
// Least-weight server id selector.
// item channel (sink): operation, server_id, weight_delta. Register appends the
// id at weight zero, add adds weight_delta to the first entry with that id (or
// appends it with that weight), any other code is a query.
// result channel (source): least_id of the first entry with the strictly
// smallest weight below all-ones (0 if none), and status (1 = table full,
// append refused). One result beat per item beat.
// Each item scans the entry memory once, one entry read per cycle, folding the
// id match, the weight update and the minimum into the same pass. The result
// reaches the output register in the same cycle that item.ready rises again,
// so a new item is accepted only after the previous item's scan is through.
// The result sits in an output register, so the next item is accepted while
// an earlier result waits; if the receiver stalls longer, the finished item
// holds in the engine and item.ready stays low until the register frees.
// Reset empties the table (entry count to zero) and clears the output valid.
module least_weight_id_selector #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	lwis_in_if.sink     item,
	lwis_out_if.source  result
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	lwis_pkg::cmd_t   cmd;
	lwis_pkg::res_t   res;
	lwis_pkg::res_t   res_q;
	lwis_pkg::entry_t rd_data;
	lwis_pkg::entry_t wr_data;
	logic             res_valid;
	logic             res_ready;
	logic             out_valid_q;
	logic             rd_en;
	logic             wr_en;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;

	assign cmd.operation    = item.operation;
	assign cmd.server_id    = item.server_id;
	assign cmd.weight_delta = item.weight_delta;

	lwis_engine #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.AW          (AW),
		.CW          (CW)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (item.valid),
		.cmd_ready (item.ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	lwis_table #(
		.DEPTH (MAX_ENTRIES),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign res_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.least_id = res_q.least_id;
	assign result.status   = res_q.status;

endmodule

/* hdl/lwis_checker.sv */
module lwis_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [lwis_pkg::ID_W-1:0] least_id,
	input logic                      status
);

	logic [1:0] pend_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// items accepted whose result beat has not gone out yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_beat} - {1'b0, out_beat};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(least_id) && $stable(status))
		else $error("result payload changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result beat without an accepted item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two items in flight");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ready)
		else $error("item accepted while previous scan runs");

endmodule

bind least_weight_id_selector lwis_checker u_lwis_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.least_id  (result.least_id),
	.status    (result.status)
);

/* tb/least_weight_id_selector_checker.sv */
`timescale 1ns / 100ps

module least_weight_id_selector_checker #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic clk,
	input  logic arst_n,
	lwis_in_if   item,
	lwis_out_if  result,
	output int   mismatches,
	output int   pending
);

	logic [lwis_pkg::ID_W-1:0]     slot_ids     [MAX_ENTRIES];
	logic [lwis_pkg::WEIGHT_W-1:0] slot_weights [MAX_ENTRIES];
	int                            slot_count = 0;
	lwis_pkg::res_t                least_q[$];
	int                            miss_n = 0;
	int                            waiting = 0;

	assign mismatches = miss_n;
	assign pending    = waiting;

	function automatic bit append_slot(logic [lwis_pkg::ID_W-1:0] id,
		logic [lwis_pkg::WEIGHT_W-1:0] weight);
		if (slot_count >= MAX_ENTRIES)
			return 1'b0;
		slot_ids[slot_count]     = id;
		slot_weights[slot_count] = weight;
		slot_count++;
		return 1'b1;
	endfunction

	// updates the shadow table and returns the least-weight id after the command
	function automatic lwis_pkg::res_t apply_cmd(lwis_pkg::cmd_t c);
		lwis_pkg::res_t                r;
		logic                          found;
		logic [lwis_pkg::WEIGHT_W-1:0] best_w;
		r.status = lwis_pkg::STATUS_DONE;
		found = 1'b0;
		if (c.operation == lwis_pkg::OP_REGISTER) begin
			if (!append_slot(c.server_id, '0))
				r.status = lwis_pkg::STATUS_FULL;
		end else if (c.operation == lwis_pkg::OP_ADD) begin
			for (int i = 0; i < slot_count; i++) begin
				if (!found && slot_ids[i] == c.server_id) begin
					slot_weights[i] = slot_weights[i] + c.weight_delta;
					found = 1'b1;
				end
			end
			if (!found && !append_slot(c.server_id, c.weight_delta))
				r.status = lwis_pkg::STATUS_FULL;
		end
		// strict compare: earliest entry wins a tie, saturated weights never win
		r.least_id = '0;
		best_w = lwis_pkg::WEIGHT_LIMIT;
		for (int i = 0; i < slot_count; i++) begin
			if (slot_weights[i] < best_w) begin
				best_w = slot_weights[i];
				r.least_id = slot_ids[i];
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what);
		miss_n++;
		if (miss_n <= 10)
			$display("%0t: mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		lwis_pkg::res_t want;
		lwis_pkg::cmd_t c;
		if (!arst_n) begin
			slot_count = 0;
			least_q.delete();
			waiting = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (least_q.size() == 0) begin
					report_mismatch($sformatf(
						"result beat with nothing pending: least_id %h status %b",
						result.least_id, result.status));
				end else begin
					want = least_q.pop_front();
					if (result.least_id !== want.least_id)
						report_mismatch($sformatf("least_id: expected %h, got %h",
							want.least_id, result.least_id));
					if (result.status !== want.status)
						report_mismatch($sformatf("status: expected %b, got %b",
							want.status, result.status));
				end
			end
			if (item.valid && item.ready) begin
				c = {item.operation, item.server_id, item.weight_delta};
				least_q.insert(least_q.size(), apply_cmd(c));
			end
			waiting = least_q.size();
		end
	end

endmodule

/* tb/least_weight_id_selector_tb.sv */
`timescale 1ns / 100ps

module least_weight_id_selector_tb;

	localparam int MAX_ENTRIES  = 16;
	localparam int RANDOM_ITEMS = 2000;
	localparam int CALM_ITEMS   = 300;

	localparam logic [lwis_pkg::OP_W-1:0] OP_QUERY = 2'd2;
	localparam logic [lwis_pkg::OP_W-1:0] OP_SPARE = 2'd3;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic calm   = 1'b0;
	int   mismatches;
	int   pending;

	logic [lwis_pkg::ID_W-1:0] known_ids[$];

	lwis_in_if  item();
	lwis_out_if result();

	least_weight_id_selector #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	least_weight_id_selector_checker #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) least_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.result     (result),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	initial begin
		#10_000_000;
		$display("least_weight_id_selector_tb: done, errors");
		$finish;
	end

	// result side: random stall bursts, always ready once calm
	initial begin
		int hold;
		hold = 0;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm) begin
				result.ready <= 1'b1;
			end else if (hold > 0) begin
				hold--;
			end else if ($urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 9) - 1;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	function automatic bit is_known(logic [lwis_pkg::ID_W-1:0] id);
		foreach (known_ids[i])
			if (known_ids[i] == id)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [lwis_pkg::WEIGHT_W-1:0] pick_delta();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 15);
			1: return $urandom;
			2: return lwis_pkg::WEIGHT_LIMIT - $urandom_range(0, 15);
			3: return lwis_pkg::WEIGHT_LIMIT;
			default: return 32'h8000_0000 | $urandom_range(0, 15);
		endcase
	endfunction

	// returns right after the posedge that took the beat
	task automatic send_item(input logic [lwis_pkg::OP_W-1:0] op,
		input logic [lwis_pkg::ID_W-1:0] id,
		input logic [lwis_pkg::WEIGHT_W-1:0] delta);
		@(negedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			item.valid        <= 1'b0;
			item.operation    <= lwis_pkg::OP_W'($urandom_range(0, 3));
			item.server_id    <= lwis_pkg::ID_W'($urandom);
			item.weight_delta <= $urandom;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		item.valid        <= 1'b1;
		item.operation    <= op;
		item.server_id    <= id;
		item.weight_delta <= delta;
		do @(posedge clk); while (item.ready !== 1'b1);
		if (known_ids.size() < MAX_ENTRIES &&
			(op == lwis_pkg::OP_REGISTER || (op == lwis_pkg::OP_ADD && !is_known(id))))
			known_ids.insert(known_ids.size(), id);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		logic [lwis_pkg::ID_W-1:0] fresh;
		int                        pick;
		item.valid        = 1'b0;
		item.operation    = lwis_pkg::OP_REGISTER;
		item.server_id    = '0;
		item.weight_delta = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table, then ties, saturation, wrap and duplicates
		send_item(OP_QUERY,              16'hffff, 32'hffff_ffff);
		send_item(OP_SPARE,              16'h0000, 32'h0000_0000);
		send_item(lwis_pkg::OP_ADD,      16'hffff, 32'd5);
		send_item(lwis_pkg::OP_REGISTER, 16'h0000, 32'hffff_ffff);
		send_item(lwis_pkg::OP_REGISTER, 16'h1234, 32'h0000_0000);
		send_item(lwis_pkg::OP_ADD,      16'h0000, 32'hffff_ffff);
		send_item(lwis_pkg::OP_ADD,      16'h1234, 32'd1);
		send_item(lwis_pkg::OP_ADD,      16'h1234, 32'hffff_ffff);
		send_item(lwis_pkg::OP_REGISTER, 16'h1234, 32'h0000_0000);
		send_item(lwis_pkg::OP_ADD,      16'h1234, 32'd7);
		send_item(lwis_pkg::OP_ADD,      16'h0000, 32'd1);
		send_item(OP_QUERY,              16'h5a5a, 32'h1234_5678);
		send_item(lwis_pkg::OP_ADD,      16'hffff, 32'hffff_fffa);
		wait_drained();

		// fill the table, then hit it with refused appends
		while (known_ids.size() < MAX_ENTRIES) begin
			if ($urandom_range(0, 1) == 0)
				send_item(lwis_pkg::OP_REGISTER, lwis_pkg::ID_W'($urandom), $urandom);
			else
				send_item(lwis_pkg::OP_ADD, lwis_pkg::ID_W'($urandom), pick_delta());
		end
		send_item(lwis_pkg::OP_REGISTER, 16'hffff, 32'h0000_0000);
		do fresh = lwis_pkg::ID_W'($urandom); while (is_known(fresh));
		send_item(lwis_pkg::OP_ADD, fresh, 32'hffff_ffff);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
			if (n == RANDOM_ITEMS / 2)
				wait_drained();
			pick = $urandom_range(0, 99);
			if (pick < 60)
				send_item(lwis_pkg::OP_ADD,
					known_ids[$urandom_range(0, known_ids.size() - 1)], pick_delta());
			else if (pick < 70)
				send_item(OP_QUERY, lwis_pkg::ID_W'($urandom), $urandom);
			else if (pick < 75)
				send_item(OP_SPARE, lwis_pkg::ID_W'($urandom), $urandom);
			else if (pick < 87)
				send_item(lwis_pkg::OP_ADD, lwis_pkg::ID_W'($urandom), $urandom);
			else
				send_item(lwis_pkg::OP_REGISTER, lwis_pkg::ID_W'($urandom), $urandom);
		end

		wait_drained();
		repeat (MAX_ENTRIES + 8) @(posedge clk);
		if (mismatches == 0)
			$display("least_weight_id_selector_tb: done, clean");
		else
			$display("least_weight_id_selector_tb: done, errors");
		$finish;
	end

endmodule
